// File: design/lzsd_pkg.sv
// shared types and constants for the lzss stream decompressor
package lzsd_pkg;

	// window geometry and stream start values
	localparam int unsigned WIN_AW      = 12;
	localparam logic [WIN_AW-1:0] WIN_START = 12'hFEE;
	localparam logic [7:0]  WIN_FILL    = 8'h20;
	localparam logic [4:0]  LEN_BIAS    = 5'd3;
	localparam logic [3:0]  CTL_USED_FULL = 4'd8;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REF_RD,
		ST_COPY,
		ST_LIT,
		ST_TRUNC
	} state_t;

	// datapath operations
	typedef enum logic [2:0] {
		OP_NONE,
		OP_TAKE,
		OP_RD_FIRST,
		OP_EMIT_LIT,
		OP_EMIT_REF,
		OP_EMIT_TRUNC
	} op_t;

	// class of the incoming compressed byte
	typedef enum logic [2:0] {
		KIND_IGNORE,
		KIND_FLAG,
		KIND_LIT,
		KIND_LOW,
		KIND_REF
	} kind_t;

	// controller to datapath
	typedef struct packed {
		op_t op;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  slot_free;
		logic  ref_last;
	} stat_t;

endpackage

// File: design/lzsd_ctrl.sv
// controller state machine for the lzss stream decompressor
module lzsd_ctrl
	import lzsd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	input  logic  s_tlast,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (stat.kind)
						KIND_REF:  state_d = ST_REF_RD;
						KIND_LIT:  state_d = ST_LIT;
						KIND_FLAG,
						KIND_LOW:  state_d = s_tlast ? ST_TRUNC : ST_IDLE;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_REF_RD: state_d = ST_COPY;
			ST_COPY: begin
				if (stat.slot_free && stat.ref_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_LIT,
			ST_TRUNC: begin
				if (stat.slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = 1'b0;
		cmd.op   = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op = OP_TAKE;
				end
			end
			ST_REF_RD: cmd.op = OP_RD_FIRST;
			ST_COPY: begin
				if (stat.slot_free) begin
					cmd.op = OP_EMIT_REF;
				end
			end
			ST_LIT: begin
				if (stat.slot_free) begin
					cmd.op = OP_EMIT_LIT;
				end
			end
			ST_TRUNC: begin
				if (stat.slot_free) begin
					cmd.op = OP_EMIT_TRUNC;
				end
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

// File: design/lzsd_datapath.sv
// decoder registers, history window and output register
module lzsd_datapath
	import lzsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  cmd_t        cmd,
	output stat_t       stat,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic [2:0]  m_tuser,
	output logic        m_tlast
);

	// control state
	logic [31:0]       size_q;
	logic [WIN_AW-1:0] wp_q;
	logic [7:0]        ctl_q;
	logic [3:0]        used_q;
	logic [7:0]        low_q;
	logic              await_q;
	logic [31:0]       produced_q;
	logic              fin_q;
	logic              out_valid_q;

	// payload state
	logic [7:0]        byte_q;
	logic              last_q;
	logic [WIN_AW-1:0] ra_q;
	logic [4:0]        k_q;
	logic [4:0]        len_q;
	logic [7:0]        rd_q;
	logic              rvalid_q;
	logic              fwd_q;
	logic [7:0]        fwd_data_q;
	logic [7:0]        out_data_q;
	logic [2:0]        out_user_q;
	logic              out_last_q;

	logic [7:0] win_mem [0:(1<<WIN_AW)-1];

	logic              fin_now;
	logic              slot_free;
	kind_t             kind;
	logic [7:0]        ref_byte;
	logic [7:0]        emit_data;
	logic              emit;
	logic [31:0]       produced_inc;
	logic              done_next;
	logic              ref_last;
	logic              rd_en;
	logic [WIN_AW-1:0] rd_addr;
	logic [WIN_AW-1:0] rd_off;
	logic              rd_written;
	logic              restart;

	// classify the incoming byte
	assign fin_now = fin_q || (produced_q >= size_q);
	always_comb begin
		if (fin_now) begin
			kind = KIND_IGNORE;
		end else if (await_q) begin
			kind = KIND_REF;
		end else if (used_q >= CTL_USED_FULL) begin
			kind = KIND_FLAG;
		end else if (ctl_q[used_q[2:0]]) begin
			kind = KIND_LIT;
		end else begin
			kind = KIND_LOW;
		end
	end

	// emit bookkeeping
	assign slot_free    = !out_valid_q || m_tready;
	assign emit         = (cmd.op == OP_EMIT_LIT) || (cmd.op == OP_EMIT_REF);
	assign ref_byte     = fwd_q ? fwd_data_q : (rvalid_q ? rd_q : WIN_FILL);
	assign emit_data    = (cmd.op == OP_EMIT_LIT) ? byte_q : ref_byte;
	assign produced_inc = produced_q + 32'd1;
	assign done_next    = produced_inc >= size_q;
	assign ref_last     = (k_q == (len_q - 5'd1)) || done_next;

	assign stat.kind      = kind;
	assign stat.slot_free = slot_free;
	assign stat.ref_last  = ref_last;

	// window read: unwritten entries of this stream read as fill
	assign rd_en   = (cmd.op == OP_RD_FIRST) || ((cmd.op == OP_EMIT_REF) && !ref_last);
	assign rd_addr = (cmd.op == OP_RD_FIRST) ? ra_q : ra_q + 1'b1;
	assign rd_off  = rd_addr - WIN_START;
	assign rd_written = (|produced_q[31:WIN_AW]) || (rd_off < produced_q[WIN_AW-1:0]);

	// stream restart conditions
	always_comb begin
		restart = 1'b0;
		case (cmd.op)
			OP_TAKE:     restart = s_tlast && ((kind == KIND_IGNORE) ||
			                                   (kind == KIND_FLAG) ||
			                                   (kind == KIND_LOW));
			OP_EMIT_LIT: restart = last_q;
			OP_EMIT_REF: restart = last_q && ref_last;
			default:     restart = 1'b0;
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	// stream control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= WIN_START;
			ctl_q      <= '0;
			used_q     <= CTL_USED_FULL;
			low_q      <= '0;
			await_q    <= 1'b0;
			produced_q <= '0;
			fin_q      <= 1'b0;
		end else if (restart) begin
			wp_q       <= WIN_START;
			ctl_q      <= '0;
			used_q     <= CTL_USED_FULL;
			low_q      <= '0;
			await_q    <= 1'b0;
			produced_q <= '0;
			fin_q      <= 1'b0;
		end else begin
			if (cmd.op == OP_TAKE) begin
				case (kind)
					KIND_IGNORE: fin_q <= 1'b1;
					KIND_FLAG: begin
						ctl_q  <= s_tdata;
						used_q <= '0;
					end
					KIND_LIT: used_q <= used_q + 4'd1;
					KIND_LOW: begin
						low_q   <= s_tdata;
						await_q <= 1'b1;
					end
					KIND_REF: begin
						await_q <= 1'b0;
						used_q  <= used_q + 4'd1;
					end
					default: fin_q <= fin_q;
				endcase
			end
			if (emit) begin
				wp_q       <= wp_q + 1'b1;
				produced_q <= produced_inc;
				if (done_next) begin
					fin_q <= 1'b1;
				end
			end
		end
	end

	// item and reference payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == OP_TAKE) begin
			byte_q <= s_tdata;
			last_q <= s_tlast;
			ra_q   <= {s_tdata[7:4], low_q};
			len_q  <= {1'b0, s_tdata[3:0]} + LEN_BIAS;
			k_q    <= '0;
		end else if (cmd.op == OP_EMIT_REF) begin
			ra_q <= ra_q + 1'b1;
			k_q  <= k_q + 5'd1;
		end
	end

	// history window memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (emit) begin
			win_mem[wp_q] <= emit_data;
		end
		if (rd_en) begin
			rd_q       <= win_mem[rd_addr];
			rvalid_q   <= rd_written;
			fwd_q      <= emit && (wp_q == rd_addr);
			fwd_data_q <= emit_data;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit || (cmd.op == OP_EMIT_TRUNC)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload: user is {truncated, stream_done, data_valid}
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_EMIT_LIT: begin
				out_data_q <= emit_data;
				out_user_q <= {last_q && !done_next, done_next, 1'b1};
				out_last_q <= 1'b1;
			end
			OP_EMIT_REF: begin
				out_data_q <= emit_data;
				out_user_q <= {ref_last && last_q && !done_next, done_next, 1'b1};
				out_last_q <= ref_last;
			end
			OP_EMIT_TRUNC: begin
				out_data_q <= '0;
				out_user_q <= 3'b100;
				out_last_q <= 1'b1;
			end
			default: out_data_q <= out_data_q;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	// a result is only loaded into a free output slot
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(emit || (cmd.op == OP_EMIT_TRUNC)) |-> (!out_valid_q || m_tready))
		else $error("result loaded into a busy output slot");

	// a reference never copies past its length
	a_ref_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT_REF) |-> (k_q < len_q))
		else $error("reference copy overran its length");

	// truncation is only flagged on the last result of an item
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_user_q[2]) |-> (out_last_q && !out_user_q[1]))
		else $error("truncation on a result that is not the last one");

	// nothing is produced once the stream is finished
	a_fin_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> !emit)
		else $error("byte produced after stream finished");

endmodule

// File: design/lzss_stream_decompressor_core.sv
// top level of the lzss stream decompressor
// literal: result registered once the output slot is free, next item taken after it;
// flag and reference low bytes: next item in the cycle after; if last, truncation result first
// back reference of L bytes (3 to 18): window read, then one byte per cycle while the output
// slot is free; next item taken after the last byte; output stalls delay all of these
// reset clears stream state; unwritten window entries read as spaces via the byte count
module lzss_stream_decompressor_core
	import lzsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,     // output_size
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // in_byte
	input  logic        s_tlast,       // in_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,       // data_byte
	output logic [2:0]  m_tuser,       // data_valid, stream_done, truncated
	output logic        m_tlast        // run_last
);

	cmd_t  cmd;
	stat_t stat;

	// controller
	lzsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	lzsd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// File: verif/tb_lzss_stream_decompressor_core.sv
// testbench for the lzss stream decompressor core: directed table, random streams, predictor
`timescale 1ns / 100ps

module tb_lzss_stream_decompressor_core
	import lzsd_pkg::*;
;

	// one decompressed result as seen on the master side
	typedef struct packed {
		logic       dv;
		logic [7:0] data;
		logic       rl;
		logic       done;
		logic       trunc;
	} lz_out_t;

	// one compressed input item
	typedef struct packed {
		logic [7:0] b;
		logic       l;
	} in_item_t;

	// how a directed row is checked
	typedef enum logic [1:0] {
		CHK_PRED,
		CHK_NONE,
		CHK_ONE
	} chk_t;

	// directed row: either a size write or one input item
	typedef struct packed {
		logic        is_cfg;
		logic [31:0] size;
		logic [7:0]  b;
		logic        l;
		chk_t        chk;
		lz_out_t     r;
	} drow_t;

	localparam lz_out_t NO_RES  = '0;
	localparam int      LAT_CYC = 24;
	localparam int      DIR_ROWS = 30;
	localparam int      ITEMS_PER_SUB = 58;

	localparam drow_t DIR_TAB [DIR_ROWS] = '{
		// zero output size after reset: everything ignored
		'{1'b0, 32'd0, 8'hFF, 1'b0, CHK_NONE, NO_RES},
		'{1'b0, 32'd0, 8'h00, 1'b1, CHK_NONE, NO_RES},
		'{1'b1, 32'hFFFF_FFFF, 8'h00, 1'b0, CHK_PRED, NO_RES},
		// flag: literal then references
		'{1'b0, 32'd0, 8'h01, 1'b0, CHK_NONE, NO_RES},
		'{1'b0, 32'd0, 8'h00, 1'b0, CHK_ONE, '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0}},
		// overlapping copy starting one byte behind the write pointer
		'{1'b0, 32'd0, 8'hEE, 1'b0, CHK_NONE, NO_RES},
		'{1'b0, 32'd0, 8'hF0, 1'b0, CHK_PRED, NO_RES},
		// longest reference wrapping the window end
		'{1'b0, 32'd0, 8'hFF, 1'b0, CHK_NONE, NO_RES},
		'{1'b0, 32'd0, 8'hFF, 1'b0, CHK_PRED, NO_RES},
		// stream ends on a reference low byte
		'{1'b0, 32'd0, 8'h3C, 1'b1, CHK_ONE, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b1}},
		// stream ends on a literal
		'{1'b0, 32'd0, 8'h01, 1'b0, CHK_NONE, NO_RES},
		'{1'b0, 32'd0, 8'h80, 1'b1, CHK_ONE, '{1'b1, 8'h80, 1'b1, 1'b0, 1'b1}},
		// stream ends on its flag byte
		'{1'b0, 32'd0, 8'hA5, 1'b1, CHK_ONE, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b1}},
		// reference cut short by the output size, then ignored input
		'{1'b1, 32'd5, 8'h00, 1'b0, CHK_PRED, NO_RES},
		'{1'b0, 32'd0, 8'h00, 1'b0, CHK_NONE, NO_RES},
		'{1'b0, 32'd0, 8'h00, 1'b0, CHK_NONE, NO_RES},
		'{1'b0, 32'd0, 8'h0F, 1'b0, CHK_PRED, NO_RES},
		'{1'b0, 32'd0, 8'h12, 1'b0, CHK_NONE, NO_RES},
		'{1'b0, 32'd0, 8'h34, 1'b1, CHK_NONE, NO_RES},
		// size lowered in the middle of a stream
		'{1'b1, 32'd100, 8'h00, 1'b0, CHK_PRED, NO_RES},
		'{1'b0, 32'd0, 8'hFF, 1'b0, CHK_NONE, NO_RES},
		'{1'b0, 32'd0, 8'h41, 1'b0, CHK_ONE, '{1'b1, 8'h41, 1'b1, 1'b0, 1'b0}},
		'{1'b0, 32'd0, 8'h42, 1'b0, CHK_ONE, '{1'b1, 8'h42, 1'b1, 1'b0, 1'b0}},
		'{1'b1, 32'd1, 8'h00, 1'b0, CHK_PRED, NO_RES},
		'{1'b0, 32'd0, 8'h43, 1'b0, CHK_NONE, NO_RES},
		'{1'b0, 32'd0, 8'h44, 1'b1, CHK_NONE, NO_RES},
		// stream ends on a reference high byte
		'{1'b1, 32'hFFFF_FFFF, 8'h00, 1'b0, CHK_PRED, NO_RES},
		'{1'b0, 32'd0, 8'h00, 1'b0, CHK_NONE, NO_RES},
		'{1'b0, 32'd0, 8'h10, 1'b0, CHK_NONE, NO_RES},
		'{1'b0, 32'd0, 8'h02, 1'b1, CHK_PRED, NO_RES}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	// decoder model state
	logic [7:0]  win [4096];
	logic [11:0] wr_pos;
	logic [7:0]  flag_bits;
	logic [3:0]  flag_used;
	logic [7:0]  ref_lo;
	logic        want_hi;
	logic [31:0] n_out;
	logic        strm_done;
	logic [31:0] out_size;

	lz_out_t step_out [$];
	lz_out_t exp_bytes [$];

	chk_t    row_mode;
	lz_out_t row_res;
	int      errors;
	int      sub_items;
	int      tx_idle;
	int      rx_idle;
	int      hold_left;

	lzss_stream_decompressor_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("** lzss_stream_decompressor_core: FAILED **");
		$finish;
	end

	task automatic log_mismatch(input string msg);
		errors++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// fresh window and token state at the start of a stream
	task automatic restart_stream();
		for (int a = 0; a < 4096; a++)
			win[a] = WIN_FILL;
		wr_pos    = WIN_START;
		flag_bits = '0;
		flag_used = CTL_USED_FULL;
		ref_lo    = '0;
		want_hi   = 1'b0;
		n_out     = '0;
		strm_done = 1'b0;
	endtask

	// one decompressed byte into the window and the step results
	task automatic put_byte(input logic [7:0] v);
		win[wr_pos] = v;
		wr_pos      = wr_pos + 1'b1;
		n_out       = n_out + 1;
		if (n_out >= out_size)
			strm_done = 1'b1;
		step_out.insert(step_out.size(), lz_out_t'{1'b1, v, 1'b0, strm_done, 1'b0});
	endtask

	// decode one compressed byte, queue what the block should emit
	task automatic decode_byte(input logic [7:0] b, input logic l);
		logic [11:0] pos;
		logic [4:0]  len;
		step_out.delete();
		if (n_out >= out_size)
			strm_done = 1'b1;
		if (strm_done) begin
			if (l)
				restart_stream();
		end else begin
			if (want_hi) begin
				pos       = {b[7:4], ref_lo};
				len       = {1'b0, b[3:0]} + LEN_BIAS;
				want_hi   = 1'b0;
				flag_used = flag_used + 1'b1;
				for (int k = 0; k < len && !strm_done; k++)
					put_byte(win[pos + 12'(k)]);
			end else if (flag_used >= CTL_USED_FULL) begin
				flag_bits = b;
				flag_used = '0;
			end else if (flag_bits[flag_used[2:0]]) begin
				flag_used = flag_used + 1'b1;
				put_byte(b);
			end else begin
				ref_lo  = b;
				want_hi = 1'b1;
			end
			// end of stream, truncation marks the step's last result
			if (l) begin
				if (!strm_done) begin
					if (step_out.size() == 0)
						step_out.insert(0, NO_RES);
					step_out[step_out.size()-1].trunc = 1'b1;
				end
				restart_stream();
			end
			if (step_out.size() > 0)
				step_out[step_out.size()-1].rl = 1'b1;
		end
		case (row_mode)
			CHK_NONE: ;
			CHK_ONE:  exp_bytes.insert(exp_bytes.size(), row_res);
			default: begin
				foreach (step_out[i])
					exp_bytes.insert(exp_bytes.size(), step_out[i]);
			end
		endcase
	endtask

	// sample handshakes and config writes at the rising edge
	always @(posedge clk) begin : mon
		lz_out_t want;
		if (arst_n) begin
			if (cfg_we)
				out_size = cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (exp_bytes.size() == 0) begin
					log_mismatch($sformatf("unexpected result data %02h user %b last %b",
						m_tdata, m_tuser, m_tlast));
				end else begin
					want = exp_bytes.pop_front();
					if (m_tuser[0] !== want.dv)
						log_mismatch($sformatf("data_valid got %b want %b", m_tuser[0], want.dv));
					if (m_tdata !== want.data)
						log_mismatch($sformatf("data_byte got %02h want %02h", m_tdata, want.data));
					if (m_tlast !== want.rl)
						log_mismatch($sformatf("run_last got %b want %b", m_tlast, want.rl));
					if (m_tuser[1] !== want.done)
						log_mismatch($sformatf("stream_done got %b want %b", m_tuser[1], want.done));
					if (m_tuser[2] !== want.trunc)
						log_mismatch($sformatf("truncated got %b want %b", m_tuser[2], want.trunc));
				end
			end
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, s_tlast);
				sub_items++;
			end
		end
	end

	// receiver: random stalls plus a commanded long hold-off
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle);
			end
		end
	end

	// offer one item, wait for it to be taken; valid stays high afterwards
	task automatic send_item(input logic [7:0] b, input logic l);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < tx_idle)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// stop offering, let every expected result arrive, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (exp_bytes.size() != 0)
			@(negedge clk);
		repeat (LAT_CYC) @(negedge clk);
	endtask

	task automatic write_size(input logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 4))
			0:       return 32'hFFFF_FFFF;
			1:       return 32'($urandom_range(1, 8));
			2:       return 32'($urandom_range(9, 120));
			3:       return 32'($urandom);
			default: return 32'($urandom_range(121, 2000));
		endcase
	endfunction

	// one stream: mostly well-formed token groups, some cut short, some noise
	task automatic run_stream();
		in_item_t    items [$];
		logic [7:0]  flag;
		logic [11:0] gpos;
		logic [11:0] p;
		logic [3:0]  len;
		int          keep;
		int          room;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12))
				items.insert(items.size(),
					in_item_t'{8'($urandom), ($urandom_range(0, 9) == 0)});
		end else begin
			gpos = WIN_START;
			repeat ($urandom_range(1, 4)) begin
				flag = 8'($urandom);
				items.insert(items.size(), in_item_t'{flag, 1'b0});
				for (int i = 0; i < 8; i++) begin
					if (flag[i]) begin
						items.insert(items.size(), in_item_t'{8'($urandom), 1'b0});
						gpos = gpos + 1'b1;
					end else begin
						// mostly point back into recent output
						if ($urandom_range(0, 9) < 7)
							p = gpos - 12'($urandom_range(1, 64));
						else
							p = 12'($urandom);
						len = 4'($urandom);
						items.insert(items.size(), in_item_t'{p[7:0], 1'b0});
						items.insert(items.size(), in_item_t'{{p[11:8], len}, 1'b0});
						gpos = gpos + 12'(len) + 12'(LEN_BIAS);
					end
				end
			end
			if ($urandom_range(0, 6) == 0) begin
				keep = $urandom_range(1, items.size() - 1);
				while (items.size() > keep)
					items.delete(items.size() - 1);
			end
		end
		// keep the item count of this part within its budget
		room = ITEMS_PER_SUB - sub_items;
		while (items.size() > room)
			items.delete(items.size() - 1);
		items[items.size()-1].l = 1'b1;
		foreach (items[i])
			send_item(items[i].b, items[i].l);
	endtask

	// main sequence
	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		errors     = 0;
		sub_items  = 0;
		hold_left  = 0;
		tx_idle    = 22;
		rx_idle    = 75;
		row_mode   = CHK_PRED;
		row_res    = NO_RES;
		out_size   = '0;
		restart_stream();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIR_TAB[r].is_cfg) begin
				settle();
				write_size(DIR_TAB[r].size);
			end else begin
				row_mode = DIR_TAB[r].chk;
				row_res  = DIR_TAB[r].r;
				send_item(DIR_TAB[r].b, DIR_TAB[r].l);
			end
		end
		row_mode = CHK_PRED;

		// random streams over three idling patterns, two sizes each
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle = 22;
					rx_idle = 75;
				end
				1: begin
					tx_idle = 75;
					rx_idle = 22;
				end
				default: begin
					tx_idle = 0;
					rx_idle = 0;
				end
			endcase
			for (int sub = 0; sub < 2; sub++) begin
				settle();
				write_size((ph == 2 && sub == 0) ? 32'hFFFF_FFFF : pick_size());
				// back up the block with a long receiver stall
				if (ph == 2 && sub == 0)
					hold_left = 400;
				sub_items = 0;
				while (sub_items < ITEMS_PER_SUB)
					run_stream();
			end
		end

		// drain and look for stray results
		s_tvalid <= 1'b0;
		for (int w = 0; w < 50000 && exp_bytes.size() != 0; w++)
			@(negedge clk);
		repeat (LAT_CYC) @(negedge clk);
		if (exp_bytes.size() != 0)
			log_mismatch($sformatf("%0d expected results never arrived", exp_bytes.size()));

		if (errors == 0)
			$display("** lzss_stream_decompressor_core: PASSED **");
		else
			$display("** lzss_stream_decompressor_core: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
design/lzsd_pkg.sv
design/lzsd_ctrl.sv
design/lzsd_datapath.sv
design/lzss_stream_decompressor_core.sv
verif/tb_lzss_stream_decompressor_core.sv
